### rtl/core/bdhr_pkg.sv
// Package for the button debounce and hold-repeat core.
// Holds the event codes, register indexes, configuration, state and result types.
// No dependencies.
package bdhr_pkg;

  localparam int unsigned TIME_W = 32;
  localparam int unsigned MS_W   = 16;
  localparam int unsigned CFG_IDX_W = 2;

  typedef enum logic [1:0] {
    EV_NONE    = 2'd0,
    EV_PRESS   = 2'd1,
    EV_RELEASE = 2'd2,
    EV_HOLD    = 2'd3
  } event_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_ACTIVE_LOW     = 2'd0,
    CFG_DEBOUNCE_MS    = 2'd1,
    CFG_HOLD_FIRST_MS  = 2'd2,
    CFG_HOLD_REPEAT_MS = 2'd3
  } cfg_idx_t;

  localparam logic            RST_ACTIVE_LOW     = 1'b1;
  localparam logic [MS_W-1:0] RST_DEBOUNCE_MS    = 16'd50;
  localparam logic [MS_W-1:0] RST_HOLD_FIRST_MS  = 16'd1000;
  localparam logic [MS_W-1:0] RST_HOLD_REPEAT_MS = 16'd200;

  typedef struct packed {
    logic            active_low;
    logic [MS_W-1:0] debounce_ms;
    logic [MS_W-1:0] hold_first_ms;
    logic [MS_W-1:0] hold_repeat_ms;
  } cfg_t;

  typedef struct packed {
    logic              last_raw_pressed;
    logic              stable_pressed;
    logic [TIME_W-1:0] debounce_stamp;
    logic [TIME_W-1:0] hold_stamp;
    logic              in_repeat_phase;
  } state_t;

  typedef struct packed {
    event_t event_res;
    logic   is_pressed;
  } res_t;

endpackage

### rtl/core/bdhr_if.sv
// Stream interfaces for the button debounce and hold-repeat core.
// One interface for the sample channel and one for the result channel.
// Depends on bdhr_pkg.
interface bdhr_in_if;
  logic                         valid;
  logic                         ready;
  logic                         pin_level;
  logic [bdhr_pkg::TIME_W-1:0] now_ms;

  modport source (output valid, output pin_level, output now_ms, input ready);
  modport sink   (input valid, input pin_level, input now_ms, output ready);
endinterface

interface bdhr_out_if;
  logic       valid;
  logic       ready;
  logic [1:0] event_res;
  logic       is_pressed;

  modport source (output valid, output event_res, output is_pressed, input ready);
  modport sink   (input valid, input event_res, input is_pressed, output ready);
endinterface

### rtl/core/button_debounce_hold_repeat_core.sv
// Top level of the button debounce and hold-repeat core.
// Holds the configuration and button state registers and a two-word result buffer.
// Depends on bdhr_pkg, bdhr_if and bdhr_step.
//
// Usage: each word on in_ch is one sample of the raw pin level with a free-running
// millisecond timestamp. Each accepted sample gives exactly one word on out_ch: the
// event (none, press, release or hold) and the debounced pressed flag after the step.
// The sample is processed in the cycle it is accepted and its result is registered
// in the result buffer. One sample can be taken every cycle while in_ch.ready is high,
// the rate set by the single step-logic pass between the state and result registers.
// A two-word result buffer lets one more sample in while a result waits; in_ch.ready
// drops only when both words are held because the receiver stalls.
// Registers are written through cfg_we, cfg_idx and cfg_data: 0 active_low,
// 1 debounce_ms, 2 hold_first_ms, 3 hold_repeat_ms. Write them only while idle.
// Reset (rst_n low, synchronous) loads the default register values, puts the button
// in the released state with hold timing off, and empties the result buffer.
module button_debounce_hold_repeat_core (
  input  logic                              clk,
  input  logic                              rst_n,
  bdhr_in_if.sink                           in_ch,
  bdhr_out_if.source                        out_ch,
  input  logic                              cfg_we,
  input  logic [bdhr_pkg::CFG_IDX_W-1:0]    cfg_idx,
  input  logic [bdhr_pkg::MS_W-1:0]         cfg_data
);
  import bdhr_pkg::*;

  cfg_t       cfg_r;
  state_t     st_r;
  state_t     st_nxt;
  res_t       res;
  res_t       buf0_r;
  res_t       buf1_r;
  logic [1:0] cnt_r;
  logic       push;
  logic       pop;

  bdhr_step u_step (
    .cfg       (cfg_r),
    .st        (st_r),
    .pin_level (in_ch.pin_level),
    .now_ms    (in_ch.now_ms),
    .st_nxt    (st_nxt),
    .res       (res)
  );

  assign in_ch.ready       = (cnt_r != 2'd2);
  assign push              = in_ch.valid && in_ch.ready;
  assign pop               = out_ch.valid && out_ch.ready;
  assign out_ch.valid      = (cnt_r != 2'd0);
  assign out_ch.event_res  = buf0_r.event_res;
  assign out_ch.is_pressed = buf0_r.is_pressed;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.active_low     <= RST_ACTIVE_LOW;
      cfg_r.debounce_ms    <= RST_DEBOUNCE_MS;
      cfg_r.hold_first_ms  <= RST_HOLD_FIRST_MS;
      cfg_r.hold_repeat_ms <= RST_HOLD_REPEAT_MS;
    end else if (cfg_we) begin
      unique case (cfg_idx)
        CFG_ACTIVE_LOW:     cfg_r.active_low     <= cfg_data[0];
        CFG_DEBOUNCE_MS:    cfg_r.debounce_ms    <= cfg_data;
        CFG_HOLD_FIRST_MS:  cfg_r.hold_first_ms  <= cfg_data;
        CFG_HOLD_REPEAT_MS: cfg_r.hold_repeat_ms <= cfg_data;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= '0;
    end else if (push) begin
      st_r <= st_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= 2'd0;
    end else begin
      case ({push, pop})
        2'b10:   cnt_r <= cnt_r + 2'd1;
        2'b01:   cnt_r <= cnt_r - 2'd1;
        default: cnt_r <= cnt_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      buf0_r <= (cnt_r == 2'd2) ? buf1_r : res;
    end else if (push && (cnt_r == 2'd0)) begin
      buf0_r <= res;
    end
    if (push && !pop && (cnt_r == 2'd1)) begin
      buf1_r <= res;
    end
  end

  a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r != 2'd3)
    else $error("result buffer count out of range");

  a_hold_needs_press: assert property (@(posedge clk) disable iff (!rst_n)
    (st_r.hold_stamp != '0) |-> st_r.stable_pressed)
    else $error("hold timing active while released");

  a_event_flag: assert property (@(posedge clk) disable iff (!rst_n)
    (out_ch.valid && (buf0_r.event_res == EV_PRESS || buf0_r.event_res == EV_HOLD))
      |-> buf0_r.is_pressed)
    else $error("press or hold word without pressed flag");

  a_release_flag: assert property (@(posedge clk) disable iff (!rst_n)
    (out_ch.valid && buf0_r.event_res == EV_RELEASE) |-> !buf0_r.is_pressed)
    else $error("release word with pressed flag");

  a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
    (push && !out_ch.valid) |=> (out_ch.valid && cnt_r == 2'd1))
    else $error("accepted word did not reach the result buffer");

endmodule

### rtl/core/bdhr_step.sv
// Next-state and result logic for one button sample.
// Purely combinational; the caller holds the state and result registers.
// Depends on bdhr_pkg.
module bdhr_step (
  input  bdhr_pkg::cfg_t                cfg,
  input  bdhr_pkg::state_t              st,
  input  logic                          pin_level,
  input  logic [bdhr_pkg::TIME_W-1:0]   now_ms,
  output bdhr_pkg::state_t              st_nxt,
  output bdhr_pkg::res_t                res
);
  import bdhr_pkg::*;

  logic              raw;
  logic [TIME_W-1:0] db_stamp;
  logic [TIME_W-1:0] hold_diff;
  logic [TIME_W-1:0] db_diff;
  logic [TIME_W-1:0] delay;
  logic              hold_en;
  logic              hold_back;
  logic              hold_fire;
  logic              db_back;
  logic              take;

  assign raw       = cfg.active_low ? ~pin_level : pin_level;
  assign db_stamp  = (raw != st.last_raw_pressed) ? now_ms : st.debounce_stamp;
  assign delay     = {{(TIME_W-MS_W){1'b0}},
                      st.in_repeat_phase ? cfg.hold_repeat_ms : cfg.hold_first_ms};
  assign hold_en   = raw && (st.hold_stamp != '0);
  assign hold_back = now_ms < st.hold_stamp;
  assign hold_diff = now_ms - st.hold_stamp;
  assign hold_fire = hold_en && !hold_back && (hold_diff >= delay);
  assign db_back   = now_ms < db_stamp;
  assign db_diff   = now_ms - db_stamp;
  assign take      = !db_back && (db_diff > {{(TIME_W-MS_W){1'b0}}, cfg.debounce_ms}) &&
                     (raw != st.stable_pressed);

  always_comb begin
    st_nxt         = st;
    res.event_res  = EV_NONE;
    if (hold_fire) begin
      // A hold event ends the step: the raw flag is not recorded.
      st_nxt.debounce_stamp  = db_stamp;
      st_nxt.hold_stamp      = now_ms;
      st_nxt.in_repeat_phase = 1'b1;
      res.event_res          = EV_HOLD;
    end else begin
      st_nxt.debounce_stamp   = db_back ? now_ms : db_stamp;
      st_nxt.last_raw_pressed = raw;
      if (hold_en && hold_back) begin
        st_nxt.hold_stamp = now_ms;
      end
      if (take) begin
        st_nxt.stable_pressed = raw;
        if (raw) begin
          res.event_res          = EV_PRESS;
          st_nxt.hold_stamp      = now_ms;
          st_nxt.in_repeat_phase = 1'b0;
        end else begin
          res.event_res     = EV_RELEASE;
          st_nxt.hold_stamp = '0;
        end
      end
    end
    res.is_pressed = st_nxt.stable_pressed;
  end

endmodule
